[src/sagc_pkg.sv]
// Shared types, constants and helpers of the stereo gradient cost block.
`default_nettype none
package sagc_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_DISP  = 62;
  localparam int RING_DEPTH    = 128;
  localparam int RING_AW       = $clog2(RING_DEPTH);
  localparam int MAX_RESULTS   = 64;
  localparam int CFG_IDX_W     = 3;

  localparam logic [5:0]  RST_DISPARITY    = 6'd0;
  localparam logic        RST_MATCH_RIGHT  = 1'b0;
  localparam logic [15:0] RST_COLOR_CAP    = 16'd1835;
  localparam logic [15:0] RST_GRADIENT_CAP = 16'd524;
  localparam logic [15:0] RST_COLOR_WEIGHT = 16'd58982;
  localparam logic [15:0] RST_BORDER_VALUE = 16'd0;

  // pixel plus gray per ring entry
  localparam int ENTRY_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISPARITY    = 3'd0,
    CFG_MATCH_RIGHT  = 3'd1,
    CFG_COLOR_CAP    = 3'd2,
    CFG_GRADIENT_CAP = 3'd3,
    CFG_COLOR_WEIGHT = 3'd4,
    CFG_BORDER_VALUE = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_CHK,
    S_RDC,
    S_RDM,
    S_RDP,
    S_CAPT,
    S_WAIT
  } seq_state_e;

  typedef struct packed {
    logic [7:0] left_red;
    logic [7:0] left_green;
    logic [7:0] left_blue;
    logic [7:0] right_red;
    logic [7:0] right_green;
    logic [7:0] right_blue;
    logic       row_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cost;
    logic [9:0]  column;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] color_cap;
    logic [15:0] gradient_cap;
    logic [15:0] color_weight;
    logic [15:0] border_value;
  } cost_cfg_t;

  // operands of one cost evaluation
  typedef struct packed {
    logic [23:0] lpix;
    logic [15:0] lgray_m;
    logic [15:0] lgray_p;
    logic [23:0] rpix;
    logic [15:0] rgray_m;
    logic [15:0] rgray_p;
    logic        lhalf;
    logic        rhalf;
    logic        have;
  } cost_req_t;

  // Q0.16 gray from Q0.8 RGB, rounded
  function automatic logic [15:0] gray_of(input logic [23:0] rgb);
    logic [25:0] acc;
    acc = 26'd19595 * 26'(rgb[23:16]) + 26'd38470 * 26'(rgb[15:8])
        + 26'd7471 * 26'(rgb[7:0]) + 26'd128;
    return acc[23:8];
  endfunction

endpackage
`default_nettype wire

[src/sagc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sagc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[src/sagc_cost.sv]
// Four-stage cost pipeline: color and gradient differences, caps, weighting.
`default_nettype none
module sagc_cost (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 req_valid_i,
  input  wire sagc_pkg::cost_req_t  req_i,
  input  wire sagc_pkg::cost_cfg_t  cfg_i,
  output logic                      res_valid_o,
  output logic [15:0]               res_cost_o
);
  import sagc_pkg::*;

  logic [3:0]  vld_q;
  logic [17:0] sum_q;
  logic [18:0] gabs_q;
  logic [35:0] prod_q;
  logic [15:0] gmin_q;
  logic [31:0] p1_q;
  logic [32:0] p2_q;
  logic [15:0] cost_q;

  logic [15:0] ca [3];
  logic [15:0] cb [3];
  logic [17:0] sum_d;
  logic signed [19:0] lg, rg, gd;
  logic [18:0] gabs_d;
  logic [16:0] quo;
  logic [15:0] cmin;
  logic [33:0] acc;

  always_comb begin
    ca[0] = {req_i.lpix[23:16], 8'd0};
    ca[1] = {req_i.lpix[15:8], 8'd0};
    ca[2] = {req_i.lpix[7:0], 8'd0};
    cb[0] = req_i.have ? {req_i.rpix[23:16], 8'd0} : cfg_i.border_value;
    cb[1] = req_i.have ? {req_i.rpix[15:8], 8'd0} : cfg_i.border_value;
    cb[2] = req_i.have ? {req_i.rpix[7:0], 8'd0} : cfg_i.border_value;
    sum_d = 18'd1;
    for (int i = 0; i < 3; i++) begin
      sum_d = sum_d + 18'((ca[i] > cb[i]) ? (ca[i] - cb[i]) : (cb[i] - ca[i]));
    end
    lg = req_i.lhalf ? 20'sd32768
       : 20'(signed'({4'd0, req_i.lgray_p})) - 20'(signed'({4'd0, req_i.lgray_m}))
         + 20'sd32768;
    if (!req_i.have) begin
      rg = 20'(signed'({4'd0, cfg_i.border_value}));
    end else if (req_i.rhalf) begin
      rg = 20'sd32768;
    end else begin
      rg = 20'(signed'({4'd0, req_i.rgray_p})) - 20'(signed'({4'd0, req_i.rgray_m}))
         + 20'sd32768;
    end
    gd = lg - rg;
    gabs_d = gd[19] ? 19'(-gd) : 19'(gd);
  end

  // divide by three: multiply by ceil(2^19/3), exact below 2^19
  assign quo  = prod_q[35:19];
  assign cmin = (quo > 17'(cfg_i.color_cap)) ? cfg_i.color_cap : quo[15:0];
  assign acc  = 34'(p1_q) + 34'(p2_q) + 34'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], req_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    gabs_q <= gabs_d;
    prod_q <= 36'(sum_q) * 36'd174763;
    gmin_q <= (gabs_q > 19'(cfg_i.gradient_cap)) ? cfg_i.gradient_cap : gabs_q[15:0];
    p1_q   <= 32'(cmin) * 32'(cfg_i.color_weight);
    p2_q   <= 33'(gmin_q) * 33'(17'h10000 - 17'(cfg_i.color_weight));
    cost_q <= acc[31:16];
  end

  assign res_valid_o = vld_q[3];
  assign res_cost_o  = cost_q;

endmodule
`default_nettype wire

[src/stereo_truncated_ad_gradient_cost.sv]
// Top level of the truncated AD plus gradient stereo matching cost block.
//
// Usage: one left/right RGB pixel pair enters per item on the input channel
// (in_valid_i / in_stall_o), with row_end on the last column of a row. Cost
// items leave on the output channel (out_valid_o / out_stall_i) in column
// order; last marks the final cost of the row. The user must write registers
// through the cfg channel (cfg_valid_i / cfg_ready_o, always ready) only while
// idle; the block does not enforce this. An item that emits nothing passes
// through capture and ring write. Each emitted cost adds three reads of the
// two ring RAMs (center, left and right neighbor of both columns, one RAM
// read port each) and the four-stage cost pipeline. A row end emits every
// pending column (up to 64) back to back in that manner. A column's cost is
// emitted once its lookahead has arrived or the row has ended.
// Reset clears counters, the output register and the configuration to its
// defaults; the rings hold nothing meaningful until written.
// A stalled output holds its item; the next emission waits for the output
// register to free up, while input is still taken until an item is due to emit.
`default_nettype none
module stereo_truncated_ad_gradient_cost #(
  parameter int MAX_WIDTH = sagc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_DISP  = sagc_pkg::DEF_MAX_DISP
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire sagc_pkg::in_item_t               in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output sagc_pkg::out_item_t                   out_data_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [sagc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [15:0]                      cfg_data_i
);
  import sagc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SW = ((CW > 7) ? CW : 7) + 1;

  // configuration
  logic [5:0]  disp_q;
  logic        mr_q;
  cost_cfg_t   ccfg_q;

  // sequencer
  seq_state_e  state_q, state_d;
  in_item_t    in_q;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] emit_q, emit_d;
  logic [6:0]  k_q, k_d;
  logic        at_end_q, at_end_d;
  cost_req_t   req_q, req_d;
  logic        req_valid_q;

  // output register
  logic        out_valid_q;
  out_item_t   out_q;

  // ring RAM ports
  logic                 ram_we;
  logic [RING_AW-1:0]   waddr, lraddr, rraddr;
  logic [ENTRY_W-1:0]   lwdata, rwdata, lrdata, rrdata;

  logic        res_valid;
  logic [15:0] res_cost;

  logic [5:0]    d;
  logic [6:0]    la;
  logic [CW-1:0] p;
  logic          have, lhalf, rhalf, at_end_now, out_free, emit_more;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_q              <= RST_DISPARITY;
      mr_q                <= RST_MATCH_RIGHT;
      ccfg_q.color_cap    <= RST_COLOR_CAP;
      ccfg_q.gradient_cap <= RST_GRADIENT_CAP;
      ccfg_q.color_weight <= RST_COLOR_WEIGHT;
      ccfg_q.border_value <= RST_BORDER_VALUE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DISPARITY:    disp_q              <= cfg_data_i[5:0];
        CFG_MATCH_RIGHT:  mr_q                <= cfg_data_i[0];
        CFG_COLOR_CAP:    ccfg_q.color_cap    <= cfg_data_i;
        CFG_GRADIENT_CAP: ccfg_q.gradient_cap <= cfg_data_i;
        CFG_COLOR_WEIGHT: ccfg_q.color_weight <= cfg_data_i;
        CFG_BORDER_VALUE: ccfg_q.border_value <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // partner column and edge cases of the column being emitted
  always_comb begin
    d  = (disp_q > 6'(MAX_DISP)) ? 6'(MAX_DISP) : disp_q;
    la = mr_q ? (7'(d) + 7'd1) : 7'd1;
    if (mr_q) begin
      have = (SW'(emit_q) + SW'(d)) <= SW'(n_q);
      p    = CW'(SW'(emit_q) + SW'(d));
    end else begin
      have = SW'(emit_q) >= SW'(d);
      p    = CW'(SW'(emit_q) - SW'(d));
    end
    lhalf = (emit_q == '0) || (at_end_q && emit_q == n_q);
    rhalf = (p == '0) || (at_end_q && p == n_q);
    at_end_now = in_q.row_end || (n_q >= CW'(MAX_WIDTH - 1));
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_more = at_end_q && (emit_q != n_q) && (k_q != 7'(MAX_RESULTS - 1));

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    emit_d   = emit_q;
    k_d      = k_q;
    at_end_d = at_end_q;
    req_d    = req_q;
    ram_we   = 1'b0;
    waddr    = RING_AW'(n_q);
    lraddr   = RING_AW'(emit_q);
    rraddr   = RING_AW'(p);
    lwdata   = {in_q.left_red, in_q.left_green, in_q.left_blue,
                gray_of({in_q.left_red, in_q.left_green, in_q.left_blue})};
    rwdata   = {in_q.right_red, in_q.right_green, in_q.right_blue,
                gray_of({in_q.right_red, in_q.right_green, in_q.right_blue})};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_we   = 1'b1;
        at_end_d = at_end_now;
        k_d      = '0;
        if (at_end_now) begin
          state_d = S_CHK;
        end else if ((SW'(emit_q) + SW'(la)) <= SW'(n_q)) begin
          state_d = S_CHK;
        end else begin
          n_d     = n_q + CW'(1);
          state_d = S_IDLE;
        end
      end
      S_CHK: begin
        if (out_free) begin
          state_d = S_RDC;
        end
      end
      S_RDC: begin
        req_d.have  = have;
        req_d.lhalf = lhalf;
        req_d.rhalf = rhalf;
        state_d     = S_RDM;
      end
      S_RDM: begin
        lraddr     = RING_AW'(emit_q - CW'(1));
        rraddr     = RING_AW'(p - CW'(1));
        req_d.lpix = lrdata[39:16];
        req_d.rpix = rrdata[39:16];
        state_d    = S_RDP;
      end
      S_RDP: begin
        lraddr        = RING_AW'(emit_q + CW'(1));
        rraddr        = RING_AW'(p + CW'(1));
        req_d.lgray_m = lrdata[15:0];
        req_d.rgray_m = rrdata[15:0];
        state_d       = S_CAPT;
      end
      S_CAPT: begin
        req_d.lgray_p = lrdata[15:0];
        req_d.rgray_p = rrdata[15:0];
        state_d       = S_WAIT;
      end
      S_WAIT: begin
        if (res_valid) begin
          if (emit_more) begin
            emit_d  = emit_q + CW'(1);
            k_d     = k_q + 7'd1;
            state_d = S_CHK;
          end else if (at_end_q) begin
            emit_d  = '0;
            n_d     = '0;
            state_d = S_IDLE;
          end else begin
            emit_d  = emit_q + CW'(1);
            n_d     = n_q + CW'(1);
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      emit_q      <= '0;
      k_q         <= '0;
      at_end_q    <= 1'b0;
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      emit_q      <= emit_d;
      k_q         <= k_d;
      at_end_q    <= at_end_d;
      req_valid_q <= (state_q == S_CAPT);
      if (state_q == S_WAIT && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (state_q == S_IDLE && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (state_q == S_WAIT && res_valid) begin
      out_q.cost   <= res_cost;
      out_q.column <= 10'(emit_q);
      out_q.last   <= at_end_q && (emit_q == n_q);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  sagc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_left_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (lwdata),
    .raddr_i (lraddr),
    .rdata_o (lrdata)
  );

  sagc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_right_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (rwdata),
    .raddr_i (rraddr),
    .rdata_o (rrdata)
  );

  sagc_cost u_cost (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_q),
    .req_i       (req_q),
    .cfg_i       (ccfg_q),
    .res_valid_o (res_valid),
    .res_cost_o  (res_cost)
  );

endmodule
`default_nettype wire
